// ===== hdl/wqvg_pkg.sv =====
// Shared types and constants for the wall quad vertex generator.
package wqvg_pkg;

  localparam int SQ_W   = 84;  // squared length scaled by 2^16
  localparam int LEN_W  = 43;  // length in Q35.8
  localparam int SQRT_STEPS = 43;
  localparam int NUM_W  = 55;  // |d| << 22
  localparam int Q_W    = 56;
  localparam int DIV_STEPS = 56;
  localparam logic [15:0] Q14_ONE = 16'sd16384;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic signed [31:0] wall_height;
  } wall_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        tex_u;
    logic               tex_v;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_z;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic               last_vertex;
    logic               degenerate;
  } vertex_t;

  // Data that travels along the cell chain with one wall.
  typedef struct packed {
    wall_t              wall;
    logic [2:0][32:0]   dabs;   // |dx|,|dy|,|dz|
    logic [2:0]         dneg;
    logic               degen;
    logic [SQ_W-1:0]    sq;     // remaining radicand
    logic [LEN_W-1:0]   root;
    logic [2:0][NUM_W+LEN_W-1:0] rem;
    logic [2:0][Q_W-1:0] quo;
  } chain_t;

endpackage

// ===== hdl/wqvg_if.sv =====
// Valid/ready stream interface carrying one payload per beat.
interface wqvg_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/wqvg_sqrt_cell.sv =====
// One restoring square-root step on the chain.
module wqvg_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic               clk,
  input  logic               en,
  input  wqvg_pkg::chain_t   d_in,
  output wqvg_pkg::chain_t   d_out
);
  logic [wqvg_pkg::LEN_W-1:0] cand;
  logic [2*wqvg_pkg::LEN_W-1:0] prod;
  wqvg_pkg::chain_t nxt;

  always_comb begin
    cand = d_in.root | (wqvg_pkg::LEN_W'(1) << BIT);
    // cand^2 = root^2 + 2*root*2^b + 2^2b; sq holds n - root^2.
    prod = ((2*wqvg_pkg::LEN_W)'(d_in.root) << (BIT + 1))
         + ((2*wqvg_pkg::LEN_W)'(1) << (2 * BIT));
    nxt = d_in;
    if ((2*wqvg_pkg::LEN_W)'(d_in.sq) >= prod) begin
      nxt.root = cand;
      nxt.sq   = d_in.sq - wqvg_pkg::SQ_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_out <= nxt;
  end
endmodule

// ===== hdl/wqvg_div_cell.sv =====
// One restoring divide step for all three tangent components.
module wqvg_div_cell #(
  parameter int BIT = 0
) (
  input  logic               clk,
  input  logic               en,
  input  wqvg_pkg::chain_t   d_in,
  output wqvg_pkg::chain_t   d_out
);
  localparam int RW = wqvg_pkg::NUM_W + wqvg_pkg::LEN_W;
  wqvg_pkg::chain_t nxt;
  logic [RW-1:0] sub;

  always_comb begin
    nxt = d_in;
    sub = RW'(d_in.root) << BIT;
    for (int i = 0; i < 3; i++) begin
      if (d_in.rem[i] >= sub) begin
        nxt.rem[i] = d_in.rem[i] - sub;
        nxt.quo[i][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_out <= nxt;
  end
endmodule

// ===== hdl/wall_quad_vertex_generator_unit.sv =====
// Top level: cell chain for length and tangent, then a six-beat vertex emitter.
// Path from input beat to first vertex beat: entry stage, 43 root cells, 56 divide
// cells, exit stage, emitter load. The emitter plays six vertex beats per wall and loads
// the next wall when the last beat is taken; the chain itself advances every
// cycle it is not stalled. Reset (synchronous, rst_n low) clears chain valid bits and the emitter.
module wall_quad_vertex_generator_unit (
  input  logic clk,
  input  logic rst_n,
  wqvg_if.sink   in_ch,
  wqvg_if.source out_ch
);
  localparam int NC = wqvg_pkg::SQRT_STEPS + wqvg_pkg::DIV_STEPS;
  localparam int RW = wqvg_pkg::NUM_W + wqvg_pkg::LEN_W;

  wqvg_pkg::chain_t stage [0:NC+1];
  logic [NC+1:0] vld_r;
  wqvg_pkg::wall_t w;
  wqvg_pkg::chain_t ent;
  logic adv;
  logic load;
  logic [2:0] cnt_r;
  logic busy_r;
  wqvg_pkg::chain_t hold_r;
  logic [65:0] s;
  logic [63:0] p [3];
  logic signed [32:0] d [3];

  // Chain stalls only if the last stage is full and the emitter cannot take it.
  assign adv = !vld_r[NC+1] || load;
  assign in_ch.ready = adv;
  assign w = in_ch.data;

  always_comb begin
    ent = '0;
    ent.wall = w;
    d[0] = 33'(w.end_x) - 33'(w.start_x);
    d[1] = 33'(w.end_y) - 33'(w.start_y);
    d[2] = 33'(w.end_z) - 33'(w.start_z);
    for (int i = 0; i < 3; i++) begin
      ent.dneg[i] = d[i][32];
      ent.dabs[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
    end
    ent.degen = (d[0] == 0) && (d[1] == 0) && (d[2] == 0);
  end

  always_ff @(posedge clk) begin
    if (adv) stage[0] <= ent;
  end

  // Squares are formed in the entry stage of the chain (cell zero input).
  // A difference magnitude never exceeds 32 bits.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p[i] = stage[0].dabs[i][31:0] * stage[0].dabs[i][31:0];
    end
    s = 66'(p[0]) + 66'(p[1]) + 66'(p[2]);
  end

  wqvg_pkg::chain_t c0;
  always_comb begin
    c0 = stage[0];
    c0.sq = wqvg_pkg::SQ_W'({s, 16'h0});
    c0.root = '0;
  end

  for (genvar g = 0; g < wqvg_pkg::SQRT_STEPS; g++) begin : g_sqrt
    wqvg_sqrt_cell #(.BIT(wqvg_pkg::SQRT_STEPS - 1 - g)) u_cell (
      .clk(clk), .en(adv), .d_in(g == 0 ? c0 : stage[g]), .d_out(stage[g+1]));
  end

  // Dividend |d|<<22 plus half the length for rounding.
  wqvg_pkg::chain_t cd;
  always_comb begin
    cd = stage[wqvg_pkg::SQRT_STEPS];
    for (int i = 0; i < 3; i++) begin
      cd.rem[i] = (RW'(cd.dabs[i]) << 22) + RW'(cd.root >> 1);
      cd.quo[i] = '0;
    end
  end

  for (genvar g = 0; g < wqvg_pkg::DIV_STEPS; g++) begin : g_div
    localparam int S = wqvg_pkg::SQRT_STEPS + g;
    wqvg_div_cell #(.BIT(wqvg_pkg::DIV_STEPS - 1 - g)) u_cell (
      .clk(clk), .en(adv),
      .d_in(g == 0 ? cd : stage[S]), .d_out(stage[S+1]));
  end

  always_ff @(posedge clk) begin
    if (adv) stage[NC+1] <= stage[NC];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NC:0], in_ch.valid};
  end

  // Emitter: loads the finished wall and plays six beats.
  assign load = vld_r[NC+1] && (!busy_r || (out_ch.ready && cnt_r == 3'd5));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (out_ch.valid && out_ch.ready) begin
      cnt_r <= (cnt_r == 3'd5) ? 3'd0 : cnt_r + 3'd1;
      if (cnt_r == 3'd5) busy_r <= load;
    end else if (load) begin
      busy_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) hold_r <= stage[NC+1];
  end

  logic atend, bot;
  logic signed [32:0] ytop;
  logic signed [31:0] ybase, ysat;
  logic signed [15:0] t [3];
  logic [42:0] u43;
  wqvg_pkg::vertex_t v;

  always_comb begin
    unique case (cnt_r)
      3'd0: begin atend = 1'b0; bot = 1'b0; end
      3'd1: begin atend = 1'b0; bot = 1'b1; end
      3'd2: begin atend = 1'b1; bot = 1'b0; end
      3'd3: begin atend = 1'b1; bot = 1'b0; end
      3'd4: begin atend = 1'b0; bot = 1'b1; end
      default: begin atend = 1'b1; bot = 1'b1; end
    endcase
    ybase = atend ? hold_r.wall.end_y : hold_r.wall.start_y;
    ytop = 33'(ybase) + 33'(hold_r.wall.wall_height);
    if (ytop > 33'sd2147483647) ysat = 32'sh7FFFFFFF;
    else if (ytop < -33'sd2147483648) ysat = 32'sh80000000;
    else ysat = ytop[31:0];
    for (int i = 0; i < 3; i++) begin
      logic [15:0] m;
      m = (hold_r.quo[i] > wqvg_pkg::Q_W'(wqvg_pkg::Q14_ONE)) ? wqvg_pkg::Q14_ONE
        : hold_r.quo[i][15:0];
      t[i] = hold_r.degen ? 16'sd0 : (hold_r.dneg[i] ? -$signed(m) : $signed(m));
    end
    u43 = hold_r.root >> 11;
    v.pos_x = atend ? hold_r.wall.end_x : hold_r.wall.start_x;
    v.pos_y = bot ? ybase : ysat;
    v.pos_z = atend ? hold_r.wall.end_z : hold_r.wall.start_z;
    v.tex_u = (!atend || hold_r.degen) ? 31'd0
            : (u43 > 43'h7FFFFFFF ? 31'h7FFFFFFF : u43[30:0]);
    v.tex_v = bot;
    v.normal_x = -t[2];
    v.normal_z = t[0];
    v.tangent_x = t[0];
    v.tangent_y = t[1];
    v.tangent_z = t[2];
    v.last_vertex = (cnt_r == 3'd5);
    v.degenerate = hold_r.degen;
  end

  assign out_ch.valid = busy_r;
  assign out_ch.data  = v;
endmodule

// ===== hdl/wqvg_checker.sv =====
// Port-level checks for the vertex generator, bound to the top level.
module wqvg_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic out_tex_v,
  input logic out_degen,
  input logic [30:0] out_tex_u
);
  a_last_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_tex_v) else $error("last vertex not bottom");
  a_degen_u: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degen |-> out_tex_u == 31'd0) else $error("degenerate u nonzero");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("valid dropped");
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !(out_valid && out_last))
    else $error("two last beats in a row");
endmodule

bind wall_quad_vertex_generator_unit wqvg_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_last(out_ch.data.last_vertex), .out_tex_v(out_ch.data.tex_v),
  .out_degen(out_ch.data.degenerate), .out_tex_u(out_ch.data.tex_u));
